[src/ial_pkg.sv]
// Shared types, codes and lookup functions of the indent-aware token lexer.
package ial_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int LINE_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH     = 4;

    // Result kinds
    localparam logic [1:0] K_TEXT   = 2'd0;
    localparam logic [1:0] K_RECORD = 2'd1;
    localparam logic [1:0] K_ERROR  = 2'd2;

    // Error codes
    localparam logic [1:0] E_UNTERM  = 2'd0;
    localparam logic [1:0] E_BANG    = 2'd1;
    localparam logic [1:0] E_UNKNOWN = 2'd2;
    localparam logic [1:0] E_STACK   = 2'd3;

    // Token types
    localparam logic [5:0] TK_INDENT  = 6'd0;
    localparam logic [5:0] TK_DEDENT  = 6'd1;
    localparam logic [5:0] TK_NEWLINE = 6'd2;
    localparam logic [5:0] TK_NUMBER  = 6'd3;
    localparam logic [5:0] TK_STRING  = 6'd4;
    localparam logic [5:0] TK_IDENT   = 6'd5;
    localparam logic [5:0] TK_KW_BASE = 6'd6;
    localparam logic [5:0] TK_ASSIGN  = 6'd21;
    localparam logic [5:0] TK_EQUAL   = 6'd22;
    localparam logic [5:0] TK_NOTEQ   = 6'd23;
    localparam logic [5:0] TK_LT      = 6'd24;
    localparam logic [5:0] TK_LE      = 6'd25;
    localparam logic [5:0] TK_GT      = 6'd26;
    localparam logic [5:0] TK_GE      = 6'd27;
    localparam logic [5:0] TK_PLUS    = 6'd28;
    localparam logic [5:0] TK_MINUS   = 6'd29;
    localparam logic [5:0] TK_STAR    = 6'd30;
    localparam logic [5:0] TK_SLASH   = 6'd31;
    localparam logic [5:0] TK_LPAREN  = 6'd32;
    localparam logic [5:0] TK_RPAREN  = 6'd33;
    localparam logic [5:0] TK_LBRACK  = 6'd34;
    localparam logic [5:0] TK_RBRACK  = 6'd35;
    localparam logic [5:0] TK_COMMA   = 6'd36;
    localparam logic [5:0] TK_EOF     = 6'd37;

    // Source bytes of interest
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_T  = 8'h74;

    localparam int KW_COUNT = 15;
    localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
        48'("Print"), 48'("If"), 48'("Elif"), 48'("Else"), 48'("While"),
        48'("For"), 48'("To"), 48'("Func"), 48'("Return"), 48'("End"),
        48'("And"), 48'("Or"), 48'("Not"), 48'("True"), 48'("False")
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd5, 3'd2, 3'd4, 3'd4, 3'd5, 3'd3, 3'd2, 3'd4, 3'd6, 3'd3,
        3'd3, 3'd2, 3'd3, 3'd4, 3'd5
    };

    typedef enum logic [3:0] {
        CL_EOS, CL_NL, CL_SP, CL_WS, CL_DIGIT, CL_ALPHA, CL_QUOTE, CL_HASH,
        CL_EQ, CL_BANG, CL_LT, CL_GT, CL_SINGLE, CL_DOT, CL_BAD
    } t_cls;

    typedef enum logic [3:0] {
        MD_NONE, MD_IDENT, MD_NUMBER, MD_STRING, MD_ESC,
        MD_EQ, MD_BANG, MD_LT, MD_GT
    } t_mode;

    typedef enum logic [3:0] {
        ST_IDLE, ST_FEED, ST_OP2, ST_OP3, ST_DISP, ST_DED, ST_TOK, ST_NL2,
        ST_NL3, ST_SGL, ST_FIN, ST_FIN2, ST_UNW, ST_RST, ST_DONE
    } t_state;

    typedef struct packed {
        logic [7:0] ch;
        t_cls       cls;
    } t_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] ttype;
        logic [7:0] tbyte;
        logic [6:0] ind;
        logic [1:0] err;
    } t_result;

    // Sort one byte into the class the lexer branches on
    function automatic t_cls classify(input logic [7:0] c);
        t_cls r;
        if (c == 8'd0) r = CL_EOS;
        else if (c == CH_NL) r = CL_NL;
        else if (c == CH_SPACE) r = CL_SP;
        else if (c == CH_TAB || c == CH_CR || c == CH_VT || c == CH_FF) r = CL_WS;
        else if (c >= "0" && c <= "9") r = CL_DIGIT;
        else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_")
            r = CL_ALPHA;
        else if (c == CH_QUOTE) r = CL_QUOTE;
        else if (c == CH_HASH) r = CL_HASH;
        else if (c == CH_EQ) r = CL_EQ;
        else if (c == CH_BANG) r = CL_BANG;
        else if (c == CH_LT) r = CL_LT;
        else if (c == CH_GT) r = CL_GT;
        else if (c == CH_DOT) r = CL_DOT;
        else if (c == "+" || c == "-" || c == "*" || c == "/" || c == "(" ||
                 c == ")" || c == "[" || c == "]" || c == ",") r = CL_SINGLE;
        else r = CL_BAD;
        return r;
    endfunction

    // Token type of a one-byte operator
    function automatic logic [5:0] single_type(input logic [7:0] c);
        logic [5:0] r;
        case (c)
            "+":     r = TK_PLUS;
            "-":     r = TK_MINUS;
            "*":     r = TK_STAR;
            "/":     r = TK_SLASH;
            "(":     r = TK_LPAREN;
            ")":     r = TK_RPAREN;
            "[":     r = TK_LBRACK;
            "]":     r = TK_RBRACK;
            default: r = TK_COMMA;
        endcase
        return r;
    endfunction

    // Keyword lookup on the kept word prefix
    function automatic logic [5:0] kw_type(input logic [47:0] wp, input logic [2:0] wl);
        logic [5:0] r;
        r = TK_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (KW_LEN[k] == wl && KW_TEXT[k] == wp) r = TK_KW_BASE + 6'(k);
        end
        return r;
    endfunction

endpackage

[src/ial_queue.sv]
// Short byte queue between the lexer front and back.
module ial_queue #(
    parameter int DEPTH = ial_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ial_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output ial_pkg::t_item o_item
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    ial_pkg::t_item r_mem [DEPTH];
    logic [AW:0] r_wr, r_rd;
    logic [AW:0] w_cnt;

    assign w_cnt   = r_wr - r_rd;
    assign o_full  = (w_cnt == (AW + 1)'(DEPTH));
    assign o_valid = (w_cnt != '0);
    assign o_item  = r_mem[r_rd[AW-1:0]];

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr[AW-1:0] == AW'(DEPTH - 1)) ?
                                {~r_wr[AW], {AW{1'b0}}} : r_wr + 1'b1;
            if (i_pop) r_rd <= (r_rd[AW-1:0] == AW'(DEPTH - 1)) ?
                               {~r_rd[AW], {AW{1'b0}}} : r_rd + 1'b1;
        end
    end

    // Store item
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr[AW-1:0]] <= i_item;
    end
endmodule

[src/ial_front.sv]
// Input side of the lexer: accept bytes, classify them and queue them.
module ial_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_ch,
    input  logic           i_pop,
    output logic           o_valid,
    output ial_pkg::t_item o_item
);
    logic           w_full;
    logic           w_push;
    ial_pkg::t_item w_item;

    // Classify the incoming byte
    assign w_item.ch  = i_ch;
    assign w_item.cls = ial_pkg::classify(i_ch);
    assign o_ready    = !w_full;
    assign w_push     = i_valid && !w_full;

    ial_queue #(.DEPTH(ial_pkg::QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .o_full  (w_full),
        .i_pop   (i_pop),
        .o_valid (o_valid),
        .o_item  (o_item)
    );
endmodule

[src/ial_back.sv]
// Lexer sequencer: carry out one queued byte at a time, each state giving at most one result.
module ial_back #(
    parameter int STACK_DEPTH = ial_pkg::STACK_DEPTH_DEF,
    parameter int LINE_BITS   = ial_pkg::LINE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  ial_pkg::t_item       i_q_item,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output ial_pkg::t_result     o_res,
    output logic [LINE_BITS-1:0] o_line,
    output logic                 o_last
);
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int TW = $clog2(STACK_DEPTH + 1);
    localparam logic [LINE_BITS-1:0] LINE_TOP = '1;

    ial_pkg::t_state r_state, n_state;
    ial_pkg::t_mode  r_mode, n_mode;
    logic [7:0]      r_ch;
    ial_pkg::t_cls   r_cls;
    logic            r_als, n_als, r_cmt, n_cmt, r_halt, n_halt;
    logic [7:0]      r_spc, n_spc;
    logic [6:0]      r_stk [STACK_DEPTH];
    logic [TW-1:0]   r_top, n_top;
    logic [6:0]      r_cur, n_cur;
    logic [LINE_BITS-1:0] r_line, n_line;
    logic [47:0]     r_wp, n_wp;
    logic [2:0]      r_wl, n_wl;

    ial_pkg::t_result r_pend, r_out, e_res;
    logic [LINE_BITS-1:0] r_pline;
    logic            r_pv, r_ov, r_olast, e_v;
    logic            w_can_out, w_adv, w_push;

    logic [6:0]      w_lvl, w_topval;
    logic            w_gt, w_lt, w_full, w_ded, w_idch, w_numch, w_is_eq;
    logic [7:0]      w_first, w_esc;
    logic [5:0]      w_one, w_two, w_kw;

    assign w_lvl    = r_spc[7:1];
    assign w_topval = (r_top == TW'(1)) ? 7'd0 : r_stk[SW'(r_top - TW'(1))];
    assign w_gt     = w_lvl > w_topval;
    assign w_lt     = w_lvl < w_topval;
    assign w_full   = r_top >= TW'(STACK_DEPTH);
    assign w_ded    = (r_top > TW'(1)) && w_lt;
    assign w_idch   = (r_cls == ial_pkg::CL_ALPHA) || (r_cls == ial_pkg::CL_DIGIT);
    assign w_numch  = (r_cls == ial_pkg::CL_DIGIT) || (r_cls == ial_pkg::CL_DOT);
    assign w_is_eq  = (r_cls == ial_pkg::CL_EQ);
    assign w_kw     = ial_pkg::kw_type(r_wp, r_wl);
    assign w_esc    = (r_ch == ial_pkg::CH_LOW_N) ? ial_pkg::CH_NL :
                      (r_ch == ial_pkg::CH_LOW_T) ? ial_pkg::CH_TAB : r_ch;

    // Pick operator bytes and types of the pending comparison
    always_comb begin
        case (r_mode)
            ial_pkg::MD_LT: begin
                w_first = ial_pkg::CH_LT; w_one = ial_pkg::TK_LT; w_two = ial_pkg::TK_LE;
            end
            ial_pkg::MD_GT: begin
                w_first = ial_pkg::CH_GT; w_one = ial_pkg::TK_GT; w_two = ial_pkg::TK_GE;
            end
            ial_pkg::MD_BANG: begin
                w_first = ial_pkg::CH_BANG; w_one = ial_pkg::TK_NOTEQ;
                w_two = ial_pkg::TK_NOTEQ;
            end
            default: begin
                w_first = ial_pkg::CH_EQ; w_one = ial_pkg::TK_ASSIGN;
                w_two = ial_pkg::TK_EQUAL;
            end
        endcase
    end

    assign w_can_out = !r_ov || i_ready;
    always_comb begin
        case (r_state)
            ial_pkg::ST_IDLE: w_adv = i_q_valid;
            ial_pkg::ST_DONE: w_adv = !r_pv || w_can_out;
            default:          w_adv = !e_v || !r_pv || w_can_out;
        endcase
    end
    assign o_pop  = (r_state == ial_pkg::ST_IDLE) && i_q_valid;
    assign w_push = e_v && w_adv && (r_state != ial_pkg::ST_DONE);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ial_pkg::ST_IDLE: n_state = ial_pkg::ST_FEED;
            ial_pkg::ST_FEED: begin
                if (r_cls == ial_pkg::CL_EOS) n_state = r_halt ? ial_pkg::ST_RST : ial_pkg::ST_FIN;
                else if (r_halt) n_state = ial_pkg::ST_DONE;
                else begin
                    case (r_mode)
                        ial_pkg::MD_STRING, ial_pkg::MD_ESC: n_state = ial_pkg::ST_DONE;
                        ial_pkg::MD_IDENT:  n_state = w_idch ? ial_pkg::ST_DONE : ial_pkg::ST_DISP;
                        ial_pkg::MD_NUMBER: n_state = w_numch ? ial_pkg::ST_DONE : ial_pkg::ST_DISP;
                        ial_pkg::MD_EQ, ial_pkg::MD_LT, ial_pkg::MD_GT: n_state = ial_pkg::ST_OP2;
                        ial_pkg::MD_BANG:   n_state = w_is_eq ? ial_pkg::ST_OP2 : ial_pkg::ST_DONE;
                        default:            n_state = ial_pkg::ST_DISP;
                    endcase
                end
            end
            ial_pkg::ST_OP2: n_state = w_is_eq ? ial_pkg::ST_OP3 : ial_pkg::ST_DISP;
            ial_pkg::ST_OP3: n_state = ial_pkg::ST_DONE;
            ial_pkg::ST_DISP: begin
                if (r_cls == ial_pkg::CL_HASH || r_cmt) n_state = ial_pkg::ST_DONE;
                else if (r_als && r_cls != ial_pkg::CL_NL) begin
                    if (r_cls == ial_pkg::CL_SP) n_state = ial_pkg::ST_DONE;
                    else if (w_gt) n_state = w_full ? ial_pkg::ST_DONE : ial_pkg::ST_TOK;
                    else if (w_lt) n_state = ial_pkg::ST_DED;
                    else n_state = ial_pkg::ST_TOK;
                end else n_state = ial_pkg::ST_TOK;
            end
            ial_pkg::ST_DED: n_state = w_ded ? ial_pkg::ST_DED : ial_pkg::ST_TOK;
            ial_pkg::ST_TOK: begin
                if (r_cls == ial_pkg::CL_NL) n_state = ial_pkg::ST_NL2;
                else if (r_cls == ial_pkg::CL_SINGLE) n_state = ial_pkg::ST_SGL;
                else n_state = ial_pkg::ST_DONE;
            end
            ial_pkg::ST_NL2: n_state = ial_pkg::ST_NL3;
            ial_pkg::ST_NL3: n_state = ial_pkg::ST_DONE;
            ial_pkg::ST_SGL: n_state = ial_pkg::ST_DONE;
            ial_pkg::ST_FIN: begin
                case (r_mode)
                    ial_pkg::MD_STRING, ial_pkg::MD_ESC, ial_pkg::MD_BANG:
                        n_state = ial_pkg::ST_RST;
                    ial_pkg::MD_EQ, ial_pkg::MD_LT, ial_pkg::MD_GT: n_state = ial_pkg::ST_FIN2;
                    default: n_state = ial_pkg::ST_UNW;
                endcase
            end
            ial_pkg::ST_FIN2: n_state = ial_pkg::ST_UNW;
            ial_pkg::ST_UNW:  n_state = (r_top > TW'(1)) ? ial_pkg::ST_UNW : ial_pkg::ST_RST;
            ial_pkg::ST_RST:  n_state = ial_pkg::ST_DONE;
            ial_pkg::ST_DONE: n_state = ial_pkg::ST_IDLE;
            default:          n_state = ial_pkg::ST_IDLE;
        endcase
    end

    // Result produced in this state
    always_comb begin
        e_v         = 1'b0;
        e_res.kind  = ial_pkg::K_TEXT;
        e_res.ttype = ial_pkg::TK_INDENT;
        e_res.tbyte = 8'd0;
        e_res.ind   = r_cur;
        e_res.err   = ial_pkg::E_UNTERM;
        case (r_state)
            ial_pkg::ST_FEED: begin
                if (r_cls != ial_pkg::CL_EOS && !r_halt) begin
                    case (r_mode)
                        ial_pkg::MD_STRING: begin
                            if (r_cls == ial_pkg::CL_QUOTE) begin
                                e_v = 1'b1; e_res.kind = ial_pkg::K_RECORD;
                                e_res.ttype = ial_pkg::TK_STRING;
                            end else if (r_ch != ial_pkg::CH_BSLASH) begin
                                e_v = 1'b1; e_res.ttype = ial_pkg::TK_STRING;
                                e_res.tbyte = r_ch;
                            end
                        end
                        ial_pkg::MD_ESC: begin
                            e_v = 1'b1; e_res.ttype = ial_pkg::TK_STRING; e_res.tbyte = w_esc;
                        end
                        ial_pkg::MD_IDENT: begin
                            e_v = 1'b1;
                            if (w_idch) begin
                                e_res.ttype = ial_pkg::TK_IDENT; e_res.tbyte = r_ch;
                            end else begin
                                e_res.kind = ial_pkg::K_RECORD; e_res.ttype = w_kw;
                            end
                        end
                        ial_pkg::MD_NUMBER: begin
                            e_v = 1'b1; e_res.ttype = ial_pkg::TK_NUMBER;
                            if (w_numch) e_res.tbyte = r_ch;
                            else e_res.kind = ial_pkg::K_RECORD;
                        end
                        ial_pkg::MD_EQ, ial_pkg::MD_LT, ial_pkg::MD_GT: begin
                            e_v = 1'b1; e_res.tbyte = w_first;
                            e_res.ttype = w_is_eq ? w_two : w_one;
                        end
                        ial_pkg::MD_BANG: begin
                            e_v = 1'b1;
                            if (w_is_eq) begin
                                e_res.ttype = ial_pkg::TK_NOTEQ; e_res.tbyte = w_first;
                            end else begin
                                e_res.kind = ial_pkg::K_ERROR; e_res.ind = 7'd0;
                                e_res.err = ial_pkg::E_BANG;
                            end
                        end
                        default: e_v = 1'b0;
                    endcase
                end
            end
            ial_pkg::ST_OP2: begin
                e_v = 1'b1;
                if (w_is_eq) begin
                    e_res.ttype = w_two; e_res.tbyte = ial_pkg::CH_EQ;
                end else begin
                    e_res.kind = ial_pkg::K_RECORD; e_res.ttype = w_one;
                end
            end
            ial_pkg::ST_OP3: begin
                e_v = 1'b1; e_res.kind = ial_pkg::K_RECORD; e_res.ttype = w_two;
            end
            ial_pkg::ST_DISP: begin
                if (r_cls != ial_pkg::CL_HASH && !r_cmt && r_als &&
                    r_cls != ial_pkg::CL_NL && r_cls != ial_pkg::CL_SP && w_gt) begin
                    e_v = 1'b1;
                    if (w_full) begin
                        e_res.kind = ial_pkg::K_ERROR; e_res.ind = 7'd0;
                        e_res.err = ial_pkg::E_STACK;
                    end else begin
                        e_res.kind = ial_pkg::K_RECORD; e_res.ttype = ial_pkg::TK_INDENT;
                        e_res.ind = w_lvl;
                    end
                end
            end
            ial_pkg::ST_DED: begin
                if (w_ded) begin
                    e_v = 1'b1; e_res.kind = ial_pkg::K_RECORD;
                    e_res.ttype = ial_pkg::TK_DEDENT; e_res.ind = w_lvl;
                end
            end
            ial_pkg::ST_TOK: begin
                case (r_cls)
                    ial_pkg::CL_NL: begin
                        e_v = 1'b1; e_res.ttype = ial_pkg::TK_NEWLINE;
                        e_res.tbyte = ial_pkg::CH_BSLASH;
                    end
                    ial_pkg::CL_DIGIT: begin
                        e_v = 1'b1; e_res.ttype = ial_pkg::TK_NUMBER; e_res.tbyte = r_ch;
                    end
                    ial_pkg::CL_ALPHA: begin
                        e_v = 1'b1; e_res.ttype = ial_pkg::TK_IDENT; e_res.tbyte = r_ch;
                    end
                    ial_pkg::CL_SINGLE: begin
                        e_v = 1'b1; e_res.ttype = ial_pkg::single_type(r_ch);
                        e_res.tbyte = r_ch;
                    end
                    ial_pkg::CL_BAD, ial_pkg::CL_DOT: begin
                        e_v = 1'b1; e_res.kind = ial_pkg::K_ERROR; e_res.ind = 7'd0;
                        e_res.err = ial_pkg::E_UNKNOWN;
                    end
                    default: e_v = 1'b0;
                endcase
            end
            ial_pkg::ST_NL2: begin
                e_v = 1'b1; e_res.ttype = ial_pkg::TK_NEWLINE; e_res.tbyte = ial_pkg::CH_LOW_N;
            end
            ial_pkg::ST_NL3: begin
                e_v = 1'b1; e_res.kind = ial_pkg::K_RECORD; e_res.ttype = ial_pkg::TK_NEWLINE;
            end
            ial_pkg::ST_SGL: begin
                e_v = 1'b1; e_res.kind = ial_pkg::K_RECORD;
                e_res.ttype = ial_pkg::single_type(r_ch);
            end
            ial_pkg::ST_FIN: begin
                case (r_mode)
                    ial_pkg::MD_IDENT: begin
                        e_v = 1'b1; e_res.kind = ial_pkg::K_RECORD; e_res.ttype = w_kw;
                    end
                    ial_pkg::MD_NUMBER: begin
                        e_v = 1'b1; e_res.kind = ial_pkg::K_RECORD;
                        e_res.ttype = ial_pkg::TK_NUMBER;
                    end
                    ial_pkg::MD_STRING, ial_pkg::MD_ESC: begin
                        e_v = 1'b1; e_res.kind = ial_pkg::K_ERROR; e_res.ind = 7'd0;
                        e_res.err = ial_pkg::E_UNTERM;
                    end
                    ial_pkg::MD_BANG: begin
                        e_v = 1'b1; e_res.kind = ial_pkg::K_ERROR; e_res.ind = 7'd0;
                        e_res.err = ial_pkg::E_BANG;
                    end
                    ial_pkg::MD_EQ, ial_pkg::MD_LT, ial_pkg::MD_GT: begin
                        e_v = 1'b1; e_res.ttype = w_one; e_res.tbyte = w_first;
                    end
                    default: e_v = 1'b0;
                endcase
            end
            ial_pkg::ST_FIN2: begin
                e_v = 1'b1; e_res.kind = ial_pkg::K_RECORD; e_res.ttype = w_one;
            end
            ial_pkg::ST_UNW: begin
                e_v = 1'b1; e_res.kind = ial_pkg::K_RECORD; e_res.ind = 7'd0;
                e_res.ttype = (r_top > TW'(1)) ? ial_pkg::TK_DEDENT : ial_pkg::TK_EOF;
            end
            default: e_v = 1'b0;
        endcase
    end

    // Lexer state updates
    always_comb begin
        n_mode = r_mode; n_als = r_als; n_cmt = r_cmt; n_halt = r_halt;
        n_spc = r_spc; n_top = r_top; n_cur = r_cur; n_line = r_line;
        n_wp = r_wp; n_wl = r_wl;
        case (r_state)
            ial_pkg::ST_FEED: begin
                if (r_cls != ial_pkg::CL_EOS && !r_halt) begin
                    case (r_mode)
                        ial_pkg::MD_STRING: begin
                            if (r_ch == ial_pkg::CH_BSLASH) n_mode = ial_pkg::MD_ESC;
                            else if (r_cls == ial_pkg::CL_QUOTE) n_mode = ial_pkg::MD_NONE;
                        end
                        ial_pkg::MD_ESC: n_mode = ial_pkg::MD_STRING;
                        ial_pkg::MD_IDENT: begin
                            if (w_idch) begin
                                if (r_wl < 3'd6) n_wp = {r_wp[39:0], r_ch};
                                if (r_wl < 3'd7) n_wl = r_wl + 3'd1;
                            end else n_mode = ial_pkg::MD_NONE;
                        end
                        ial_pkg::MD_NUMBER: if (!w_numch) n_mode = ial_pkg::MD_NONE;
                        ial_pkg::MD_BANG: begin
                            if (!w_is_eq) begin
                                n_halt = 1'b1; n_mode = ial_pkg::MD_NONE;
                            end
                        end
                        default: n_mode = r_mode;
                    endcase
                end
            end
            ial_pkg::ST_OP2: if (!w_is_eq) n_mode = ial_pkg::MD_NONE;
            ial_pkg::ST_OP3: n_mode = ial_pkg::MD_NONE;
            ial_pkg::ST_DISP: begin
                if (r_cls == ial_pkg::CL_HASH) begin
                    n_cmt = !r_cmt;
                    if (r_als) n_spc = 8'd0;
                end else if (r_cmt) begin
                    if (r_cls == ial_pkg::CL_NL) begin
                        if (r_line < LINE_TOP) n_line = r_line + 1'b1;
                        n_als = 1'b1; n_spc = 8'd0;
                    end
                end else if (r_als && r_cls != ial_pkg::CL_NL) begin
                    if (r_cls == ial_pkg::CL_SP) begin
                        if (r_spc != 8'hFF) n_spc = r_spc + 8'd1;
                    end else if (w_gt) begin
                        if (w_full) n_halt = 1'b1;
                        else begin
                            n_top = r_top + TW'(1); n_cur = w_lvl; n_als = 1'b0;
                        end
                    end else if (!w_lt) begin
                        n_cur = w_lvl; n_als = 1'b0;
                    end
                end
            end
            ial_pkg::ST_DED: begin
                if (w_ded) n_top = r_top - TW'(1);
                else begin
                    n_cur = w_lvl; n_als = 1'b0;
                end
            end
            ial_pkg::ST_TOK: begin
                case (r_cls)
                    ial_pkg::CL_DIGIT: n_mode = ial_pkg::MD_NUMBER;
                    ial_pkg::CL_QUOTE: n_mode = ial_pkg::MD_STRING;
                    ial_pkg::CL_ALPHA: begin
                        n_mode = ial_pkg::MD_IDENT; n_wp = {40'd0, r_ch}; n_wl = 3'd1;
                    end
                    ial_pkg::CL_EQ:   n_mode = ial_pkg::MD_EQ;
                    ial_pkg::CL_BANG: n_mode = ial_pkg::MD_BANG;
                    ial_pkg::CL_LT:   n_mode = ial_pkg::MD_LT;
                    ial_pkg::CL_GT:   n_mode = ial_pkg::MD_GT;
                    ial_pkg::CL_BAD, ial_pkg::CL_DOT: n_halt = 1'b1;
                    default: n_mode = r_mode;
                endcase
            end
            ial_pkg::ST_NL3: begin
                if (r_line < LINE_TOP) n_line = r_line + 1'b1;
                n_als = 1'b1; n_spc = 8'd0;
            end
            ial_pkg::ST_UNW: if (r_top > TW'(1)) n_top = r_top - TW'(1);
            ial_pkg::ST_RST: begin
                n_mode = ial_pkg::MD_NONE; n_als = 1'b1; n_cmt = 1'b0; n_halt = 1'b0;
                n_spc = 8'd0; n_top = TW'(1); n_cur = 7'd0;
                n_line = LINE_BITS'(1); n_wp = 48'd0; n_wl = 3'd0;
            end
            default: n_mode = r_mode;
        endcase
    end

    // Advance control and lexer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ial_pkg::ST_IDLE;
            r_mode  <= ial_pkg::MD_NONE;
            r_als   <= 1'b1;
            r_cmt   <= 1'b0;
            r_halt  <= 1'b0;
            r_spc   <= 8'd0;
            r_top   <= TW'(1);
            r_cur   <= 7'd0;
            r_line  <= LINE_BITS'(1);
            r_wp    <= 48'd0;
            r_wl    <= 3'd0;
        end else if (w_adv) begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_als   <= n_als;
            r_cmt   <= n_cmt;
            r_halt  <= n_halt;
            r_spc   <= n_spc;
            r_top   <= n_top;
            r_cur   <= n_cur;
            r_line  <= n_line;
            r_wp    <= n_wp;
            r_wl    <= n_wl;
        end
    end

    // Latch the byte and push indent levels
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ch  <= i_q_item.ch;
            r_cls <= i_q_item.cls;
        end
        if (w_adv && r_state == ial_pkg::ST_DISP && n_top != r_top)
            r_stk[SW'(r_top)] <= w_lvl;
    end

    // Hold one result back so the last flag is known, then register it out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else if (r_state == ial_pkg::ST_DONE && r_pv && w_can_out) begin
            r_ov <= 1'b1;
            r_pv <= 1'b0;
        end else if (w_push) begin
            r_pv <= 1'b1;
            if (r_pv) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ial_pkg::ST_DONE && r_pv && w_can_out) begin
            r_out   <= r_pend;
            o_line  <= r_pline;
            r_olast <= 1'b1;
        end else if (w_push) begin
            if (r_pv) begin
                r_out   <= r_pend;
                o_line  <= r_pline;
                r_olast <= 1'b0;
            end
            r_pend  <= e_res;
            r_pline <= r_line;
        end
    end

    assign o_valid = r_ov;
    assign o_res   = r_out;
    assign o_last  = r_olast;
endmodule

[src/indent_aware_token_lexer_top.sv]
// Top level of the indent-aware token lexer.
//
//  channel  | valid    | ready    | payload
//  ---------+----------+----------+--------------------------------------------
//  source   | i_valid  | o_ready  | i_ch
//  results  | o_valid  | i_ready  | o_kind o_token_type o_text_byte o_line
//           |          |          | o_indent o_error_code o_last
//
// A byte runs from IDLE via FEED to DONE; dedent runs and the end-of-source
// unwind repeat per DEDENT, one result a cycle unless the result side stalls.
// The sequencer handling one byte at a time sets the rate; a four-entry queue
// lets the source side run ahead. Reset is synchronous, active low, and returns
// the lexer to line start, line 1. A stalled result side holds the sequencer;
// the queue keeps taking bytes until it is full.
module indent_aware_token_lexer_top #(
    parameter int STACK_DEPTH = ial_pkg::STACK_DEPTH_DEF,
    parameter int LINE_BITS   = ial_pkg::LINE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_ch,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_kind,
    output logic [5:0]           o_token_type,
    output logic [7:0]           o_text_byte,
    output logic [LINE_BITS-1:0] o_line,
    output logic [6:0]           o_indent,
    output logic [1:0]           o_error_code,
    output logic                 o_last
);
    logic             w_pop, w_qv;
    ial_pkg::t_item   w_item;
    ial_pkg::t_result w_res;

    ial_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_ch    (i_ch),
        .i_pop   (w_pop),
        .o_valid (w_qv),
        .o_item  (w_item)
    );

    ial_back #(.STACK_DEPTH(STACK_DEPTH), .LINE_BITS(LINE_BITS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_qv),
        .i_q_item  (w_item),
        .o_pop     (w_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_res     (w_res),
        .o_line    (o_line),
        .o_last    (o_last)
    );

    assign o_kind       = w_res.kind;
    assign o_token_type = w_res.ttype;
    assign o_text_byte  = w_res.tbyte;
    assign o_indent     = w_res.ind;
    assign o_error_code = w_res.err;
endmodule
